### src/qsu_pkg.sv
// Shared types and constants for the quoted string unescaper.
package qsu_pkg;

  localparam int ByteW = 8;
  localparam int KindW = 2;
  localparam int ErrW  = 3;
  localparam int NibW  = 4;

  typedef enum logic [2:0] {
    MODE_START    = 3'd0,
    MODE_UNQUOTED = 3'd1,
    MODE_QUOTED   = 3'd2,
    MODE_ESCAPE   = 3'd3,
    MODE_HEX1     = 3'd4,
    MODE_HEX2     = 3'd5,
    MODE_CLOSED   = 3'd6,
    MODE_DISCARD  = 3'd7
  } mode_t;

  typedef enum logic [KindW-1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_t;

  localparam logic [ErrW-1:0] ERR_NONE     = 3'd0;
  localparam logic [ErrW-1:0] ERR_HEX      = 3'd1;
  localparam logic [ErrW-1:0] ERR_ESCAPE   = 3'd2;
  localparam logic [ErrW-1:0] ERR_UNTERM   = 3'd3;
  localparam logic [ErrW-1:0] ERR_STRAY    = 3'd4;
  localparam logic [ErrW-1:0] ERR_TRAILING = 3'd5;

  localparam logic [ByteW-1:0] CH_NUL   = 8'h00;
  localparam logic [ByteW-1:0] CH_LF    = 8'h0a;
  localparam logic [ByteW-1:0] CH_CR    = 8'h0d;
  localparam logic [ByteW-1:0] CH_QUOTE = 8'h22;
  localparam logic [ByteW-1:0] CH_BSL   = 8'h5c;
  localparam logic [ByteW-1:0] CH_N     = 8'h6e;
  localparam logic [ByteW-1:0] CH_R     = 8'h72;
  localparam logic [ByteW-1:0] CH_X     = 8'h78;

  // output data width, padded to whole bytes
  localparam int OutDataW = ((ByteW + ErrW + 7) / 8) * 8;

  typedef struct packed {
    kind_t            kind;
    logic [ByteW-1:0] data;
    logic [ErrW-1:0]  err;
    logic             last;
  } result_t;

endpackage

### src/qsu_parser.sv
// Parse state machine: mode and hex nibble registers plus the per-byte decode.
module qsu_parser
  import qsu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             accept,
  input  logic [ByteW-1:0] in_byte,
  output logic             res_valid,
  output result_t          res
);

  mode_t            mode, mode_next;
  logic [NibW-1:0]  high_nibble, high_nibble_next;
  logic             is_hex;
  logic [NibW-1:0]  hex_val;

  always_comb begin
    is_hex  = 1'b1;
    hex_val = '0;
    if (in_byte >= 8'h30 && in_byte <= 8'h39) begin
      hex_val = NibW'(in_byte - 8'h30);
    end else if (in_byte >= 8'h61 && in_byte <= 8'h66) begin
      hex_val = NibW'(in_byte - 8'h57);
    end else if (in_byte >= 8'h41 && in_byte <= 8'h46) begin
      hex_val = NibW'(in_byte - 8'h37);
    end else begin
      is_hex = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_START;
      high_nibble <= '0;
    end else if (accept) begin
      mode        <= mode_next;
      high_nibble <= high_nibble_next;
    end
  end

  always_comb begin
    logic is_nul;
    logic [ByteW-1:0] err_mode;
    is_nul           = (in_byte == CH_NUL);
    err_mode         = '0;
    mode_next        = mode;
    high_nibble_next = high_nibble;
    res_valid        = 1'b0;
    res.kind         = KIND_BYTE;
    res.data         = in_byte;
    res.err          = ERR_NONE;
    res.last         = 1'b0;
    unique case (mode)
      MODE_START: begin
        if (is_nul) begin
          res_valid = 1'b1;
          res.kind  = KIND_DONE;
        end else if (in_byte == CH_QUOTE) begin
          mode_next = MODE_QUOTED;
        end else begin
          mode_next = MODE_UNQUOTED;
          res_valid = 1'b1;
        end
      end
      MODE_UNQUOTED: begin
        res_valid = 1'b1;
        if (is_nul) begin
          mode_next = MODE_START;
          res.kind  = KIND_DONE;
        end else if (in_byte == CH_QUOTE) begin
          res.kind  = KIND_ERR;
          res.err   = ERR_STRAY;
        end
      end
      MODE_QUOTED: begin
        if (is_nul) begin
          res_valid = 1'b1;
          res.kind  = KIND_ERR;
          res.err   = ERR_UNTERM;
        end else if (in_byte == CH_BSL) begin
          mode_next = MODE_ESCAPE;
        end else if (in_byte == CH_QUOTE) begin
          mode_next = MODE_CLOSED;
        end else begin
          res_valid = 1'b1;
        end
      end
      MODE_ESCAPE: begin
        mode_next = MODE_QUOTED;
        res_valid = 1'b1;
        if (in_byte == CH_N) begin
          res.data = CH_LF;
        end else if (in_byte == CH_R) begin
          res.data = CH_CR;
        end else if (in_byte == CH_BSL || in_byte == CH_QUOTE) begin
          res.data = in_byte;
        end else if (in_byte == CH_X) begin
          mode_next = MODE_HEX1;
          res_valid = 1'b0;
        end else begin
          res.kind = KIND_ERR;
          res.err  = ERR_ESCAPE;
        end
      end
      MODE_HEX1: begin
        if (is_hex) begin
          high_nibble_next = hex_val;
          mode_next        = MODE_HEX2;
        end else begin
          res_valid = 1'b1;
          res.kind  = KIND_ERR;
          res.err   = ERR_HEX;
        end
      end
      MODE_HEX2: begin
        res_valid = 1'b1;
        if (is_hex) begin
          mode_next = MODE_QUOTED;
          res.data  = {high_nibble, hex_val};
        end else begin
          res.kind = KIND_ERR;
          res.err  = ERR_HEX;
        end
      end
      MODE_CLOSED: begin
        res_valid = 1'b1;
        if (is_nul) begin
          mode_next = MODE_START;
          res.kind  = KIND_DONE;
        end else begin
          res.kind = KIND_ERR;
          res.err  = ERR_TRAILING;
        end
      end
      MODE_DISCARD: begin
        if (is_nul) begin
          mode_next = MODE_START;
        end
      end
      default: begin
        mode_next = MODE_START;
      end
    endcase
    // any error ends the string on NUL, otherwise drops bytes until NUL
    if (res.kind == KIND_ERR) begin
      mode_next = is_nul ? MODE_START : MODE_DISCARD;
    end
    if (res.kind != KIND_BYTE) begin
      res.data = err_mode;
      res.last = 1'b1;
    end
  end

  // Second hex digit is only ever reached from the first one
  a_hex2_from_hex1: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && mode == MODE_HEX2 && $past(mode) != MODE_HEX2)
      |-> $past(mode) == MODE_HEX1)
    else $error("entered second hex digit without first");

  // An error on a non-NUL byte must leave the parser discarding
  a_err_discard: assert property (@(posedge clk) disable iff (rst)
    (accept && res_valid && res.kind == KIND_ERR && in_byte != CH_NUL)
      |=> mode == MODE_DISCARD)
    else $error("error did not enter discard");

  // NUL always returns the parser to the start of a string
  a_nul_restart: assert property (@(posedge clk) disable iff (rst)
    (accept && in_byte == CH_NUL) |=> mode == MODE_START)
    else $error("terminator did not restart parse");

endmodule

### src/qsu_out_buf.sv
// Two-entry output buffer (result register plus skid) for the result stream.
module qsu_out_buf
  import qsu_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  result_t push_res,
  output logic    can_push,
  output logic    m_tvalid,
  input  logic    m_tready,
  output result_t m_res
);

  logic    skid_valid;
  result_t skid_res;
  logic    pop;

  assign pop      = m_tvalid && m_tready;
  assign can_push = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (pop) begin
        skid_valid <= 1'b0;
      end
    end else if (push && m_tvalid && !pop) begin
      skid_valid <= 1'b1;
    end else if (push) begin
      m_tvalid <= 1'b1;
    end else if (pop) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (pop) begin
        m_res <= skid_res;
      end
    end else if (push && m_tvalid && !pop) begin
      skid_res <= push_res;
    end else if (push) begin
      m_res <= push_res;
    end
  end

  a_skid_needs_main: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> m_tvalid)
    else $error("skid holds a beat while output is empty");

  a_skid_holds: assert property (@(posedge clk) disable iff (rst)
    (skid_valid && !pop) |=> skid_valid)
    else $error("skid beat lost");

  a_stall_to_skid: assert property (@(posedge clk) disable iff (rst)
    (push && can_push && m_tvalid && !m_tready) |=> skid_valid && m_tvalid)
    else $error("stalled push not captured in skid");

endmodule

### src/quoted_string_unescaper.sv
// Quoted string unescaper top level: stream ports, parser and output buffer.
//
// Takes one source byte per beat and accepts a new beat every cycle while
// s_tready is high; each byte is decoded in the cycle it is accepted and its
// result (if any) is registered in the output buffer before it appears on the
// master side. A two-entry output buffer (result register plus skid) sits
// between the sides: s_tready depends only on the skid register, so the
// block keeps taking bytes while one result waits and stops only when two
// results are held. A string yields its decoded bytes, then one done or
// error beat with m_tlast high; after an error the bytes up to the NUL
// terminator give no beats.
module quoted_string_unescaper
  import qsu_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [ByteW-1:0]    s_tdata,   // [7:0] in_byte
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [OutDataW-1:0] m_tdata,   // [7:0] out_byte, [10:8] error_code, rest 0
  output logic [KindW-1:0]    m_tuser,   // [1:0] out_kind
  output logic                m_tlast    // is_last
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t m_res;
  logic    can_push;

  assign s_tready = can_push;
  assign accept   = s_tvalid && can_push;

  qsu_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  qsu_out_buf u_out_buf (
    .clk      (clk),
    .rst      (rst),
    .push     (accept && res_valid),
    .push_res (res),
    .can_push (can_push),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_res    (m_res)
  );

  assign m_tdata = OutDataW'({m_res.err, m_res.data});
  assign m_tuser = m_res.kind;
  assign m_tlast = m_res.last;

endmodule
